// ===== sv/pcmi_pkg.sv =====
// Shared types, codes and tables for the pixel to colormap index unit.
package pcmi_pkg;

  typedef struct packed {
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic signed [15:0] sample_ch2;
  } pixel_t;

  typedef struct packed {
    logic [7:0] shade_index;
    logic       range_error;
  } result_t;

  // lane datapath widths
  localparam int NUM_W = 27;
  localparam int DEN_W = 18;
  localparam int QUO_W = 9;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_GRAY = 2'd1;
  localparam logic [1:0] MODE_BOX  = 2'd2;
  localparam logic [1:0] MODE_CUBE = 2'd3;

  localparam logic [2:0] REG_COLOR_MODE   = 3'd0;
  localparam logic [2:0] REG_SHADE_LEVELS = 3'd1;
  localparam logic [2:0] REG_LOW_CH0      = 3'd2;
  localparam logic [2:0] REG_LOW_CH1      = 3'd3;
  localparam logic [2:0] REG_LOW_CH2      = 3'd4;
  localparam logic [2:0] REG_HIGH_CH0     = 3'd5;
  localparam logic [2:0] REG_HIGH_CH1     = 3'd6;
  localparam logic [2:0] REG_HIGH_CH2     = 3'd7;

  localparam int LN2_Q16 = 45426;

  // log2(1 + m/32) in Q16
  localparam logic [15:0] LOG_MANT_Q16 [32] = '{
    16'd0,     16'd2909,  16'd5732,  16'd8473,  16'd11136, 16'd13727, 16'd16248, 16'd18704,
    16'd21098, 16'd23433, 16'd25711, 16'd27936, 16'd30109, 16'd32234, 16'd34312, 16'd36346,
    16'd38336, 16'd40286, 16'd42196, 16'd44068, 16'd45904, 16'd47705, 16'd49472, 16'd51207,
    16'd52911, 16'd54584, 16'd56229, 16'd57845, 16'd59434, 16'd60997, 16'd62534, 16'd64047
  };

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] ncap;
    logic       range_error;
  } merge_ctl_t;

endpackage

// ===== sv/pcmi_lane.sv =====
// One channel lane: pipelined saturating signed divider, one quotient bit per stage.
module pcmi_lane import pcmi_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic [QUO_W-1:0]        quo
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic             sat_in;

  logic [NUM_W-1:0] rem [QUO_W];
  logic [DEN_W-1:0] dm  [QUO_W];
  logic [QUO_W-1:0] qb  [QUO_W+1];
  logic             neg [QUO_W+1];
  logic             sat [QUO_W+1];

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign sat_in  = CW'(num_mag) >= (CW'(den_mag) << QUO_W);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_mag;
      dm[0]  <= den_mag;
      qb[0]  <= '0;
      // opposite signs: truncated quotient is zero or negative, clamps to zero
      neg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      sat[0] <= sat_in;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_bit
    localparam int K = QUO_W - 1 - j;
    logic [CW-1:0] trial;
    logic          fits;

    assign trial = CW'(dm[j]) << K;
    assign fits  = CW'(rem[j]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        qb[j+1]  <= qb[j] | (QUO_W'(fits) << K);
        neg[j+1] <= neg[j];
        sat[j+1] <= sat[j];
      end
    end

    if (j < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= fits ? NUM_W'(CW'(rem[j]) - trial) : rem[j];
          dm[j+1]  <= dm[j];
        end
      end
    end
  end

  assign quo = neg[QUO_W] ? '0 : (sat[QUO_W] ? '1 : qb[QUO_W]);

endmodule

// ===== sv/pcmi_ratio.sv =====
// Ratio coordinate: fixed-point ln|s1/s0| scaled to 0..N-1, delayed to match the lanes.
module pcmi_ratio import pcmi_pkg::*; #(
  parameter int LOG_FRAC_BITS = 11,
  parameter int LAT = 11
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] s0,
  input  logic signed [15:0] s1,
  input  logic [8:0]         ncap,
  output logic [7:0]         iq
);

  localparam int F   = LOG_FRAC_BITS;
  localparam int LW  = F + 4;
  localparam int DW  = F + 5;
  localparam int PW  = DW + 17;
  localparam int QW  = PW - 16;
  localparam int TW  = QW + 1;
  localparam int NTW = TW - 1 + 9;
  localparam int DLY = LAT - 3;

  function automatic logic [LW-1:0] log2_fx(input logic [15:0] x);
    logic [3:0]  e;
    logic [15:0] nrm;
    logic [4:0]  m;
    logic [15:0] frac;
    e = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) e = 4'(i);
    end
    nrm  = x << (4'd15 - e);
    m    = nrm[14:10];
    frac = LOG_MANT_Q16[m] >> (16 - F);
    return LW'({e, {F{1'b0}}}) + LW'(frac);
  endfunction

  logic [15:0]          a0, a1;
  logic signed [DW-1:0] d_next, d;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] qsum;
  logic signed [TW-1:0] t;
  logic [NTW-1:0]       nt;
  logic [NTW-F-2:0]     iq_raw;
  logic [7:0]           iq_c;
  logic [7:0]           dly [DLY];

  assign a0 = s0[15] ? (~s0 + 16'd1) : s0;
  assign a1 = s1[15] ? (~s1 + 16'd1) : s1;

  // a zero sample gives a zero log ratio
  assign d_next = (s0 == 16'sd0 || s1 == 16'sd0) ? '0 :
                  $signed({1'b0, log2_fx(a1)}) - $signed({1'b0, log2_fx(a0)});

  assign qsum = prod + PW'(32768);
  assign t    = TW'($signed(qsum[PW-1:16])) + TW'(1 << F);

  assign iq_raw = nt[NTW-1:F+1];

  always_comb begin
    if (ncap == 9'd0) iq_c = 8'd0;
    else if (NTW'(iq_raw) > NTW'(ncap - 9'd1)) iq_c = 8'(ncap - 9'd1);
    else iq_c = 8'(iq_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d    <= d_next;
      prod <= PW'(d) * PW'(LN2_Q16);
      if (!t[TW-1] && t != '0) nt <= NTW'(ncap) * NTW'(t[TW-2:0]);
      else nt <= '0;
      dly[0] <= iq_c;
      for (int i = 1; i < DLY; i++) dly[i] <= dly[i-1];
    end
  end

  assign iq = dly[DLY-1];

endmodule

// ===== sv/pcmi_merge.sv =====
// Merge stage: clamps lane quotients and combines them into the colormap index.
module pcmi_merge import pcmi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  merge_ctl_t       ctl,
  input  logic [QUO_W-1:0] q0,
  input  logic [QUO_W-1:0] q1,
  input  logic [QUO_W-1:0] q2,
  input  logic [7:0]       iq,
  output result_t          res
);

  function automatic logic [7:0] clamp_n(input logic [QUO_W-1:0] q, input logic [8:0] n);
    if (n == 9'd0) return 8'd0;
    if (9'(q) > n - 9'd1) return 8'(n - 9'd1);
    return 8'(q);
  endfunction

  logic [7:0]  c0, c1, c2;
  logic [17:0] m1_next, m1;
  logic [7:0]  c2r;
  logic [27:0] full;
  logic [7:0]  idx;

  assign c0 = clamp_n(q0, ctl.ncap);
  assign c1 = clamp_n(q1, ctl.ncap);
  assign c2 = clamp_n(q2, ctl.ncap);

  always_comb begin
    case (ctl.mode)
      MODE_GRAY: m1_next = 18'(c0);
      MODE_BOX:  m1_next = 18'(iq) * 18'(ctl.ncap) + 18'(c0);
      MODE_CUBE: m1_next = 18'(c0) * 18'(ctl.ncap) + 18'(c1);
      default:   m1_next = '0;
    endcase
  end

  assign full = (ctl.mode == MODE_CUBE) ? 28'(m1) * 28'(ctl.ncap) + 28'(c2r) : 28'(m1);
  assign idx  = (full > 28'd255) ? 8'd255 : 8'(full);

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= m1_next;
      c2r <= c2;
      res.shade_index <= ctl.range_error ? 8'd0 : idx;
      res.range_error <= ctl.range_error;
    end
  end

endmodule

// ===== sv/pixel_to_colormap_index_unit.sv =====
// Top level of the pixel to colormap index unit.
//
//   channel  | direction | handshake                  | payload
//   pixel    | in        | pixel_valid / pixel_stall  | pixel_t (three signed samples)
//   index    | out       | index_valid / index_stall  | result_t (index, range error)
//   cfg      | in        | cfg_we                     | cfg_index, cfg_data
//
// One pixel per cycle while the output is not stalled; the path runs through the
// input and lane-entry registers, the nine quotient-bit stages of each lane divider,
// and the merge and output registers.
// Reset clears the configuration to its defaults and empties the pipeline.
// While the output register holds a result under stall, the whole pipeline
// holds and pixel_stall is raised; otherwise a transfer is taken every cycle.
module pixel_to_colormap_index_unit import pcmi_pkg::*; #(
  parameter int MAX_SHADES    = 256,
  parameter int LOG_FRAC_BITS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  pixel_t      pixel,
  output logic        index_valid,
  input  logic        index_stall,
  output result_t     index,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LANE_LAT = QUO_W + 1;
  localparam int DEPTH    = LANE_LAT + 3;

  logic [1:0]         color_mode;
  logic [8:0]         shade_levels;
  logic signed [15:0] low_ch [3];
  logic signed [15:0] high_ch [3];

  logic [8:0]               ncap;
  logic                     adv;
  logic [DEPTH-1:0]         vld;
  logic signed [15:0]       smp [3];
  logic signed [NUM_W-1:0]  num_next [3];
  logic signed [DEN_W-1:0]  den_next [3];
  logic signed [NUM_W-1:0]  num [3];
  logic signed [DEN_W-1:0]  den [3];
  logic [QUO_W-1:0]         quo [3];
  logic [7:0]               iq;
  logic                     box;
  logic signed [16:0]       mul_a;
  logic signed [10:0]       mul_b;
  merge_ctl_t               ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= MODE_GRAY;
      shade_levels <= 9'd256;
      for (int c = 0; c < 3; c++) begin
        low_ch[c]  <= 16'sd0;
        high_ch[c] <= 16'sd32767;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_MODE:   color_mode   <= cfg_data[1:0];
        REG_SHADE_LEVELS: shade_levels <= cfg_data[8:0];
        REG_LOW_CH0:      low_ch[0]    <= cfg_data;
        REG_LOW_CH1:      low_ch[1]    <= cfg_data;
        REG_LOW_CH2:      low_ch[2]    <= cfg_data;
        REG_HIGH_CH0:     high_ch[0]   <= cfg_data;
        REG_HIGH_CH1:     high_ch[1]   <= cfg_data;
        REG_HIGH_CH2:     high_ch[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ncap = (int'(shade_levels) > MAX_SHADES) ? 9'(MAX_SHADES) : shade_levels;

  assign adv         = !(vld[DEPTH-1] && index_stall);
  assign pixel_stall = !adv;
  assign index_valid = vld[DEPTH-1];

  assign smp[0] = pixel.sample_ch0;
  assign smp[1] = pixel.sample_ch1;
  assign smp[2] = pixel.sample_ch2;
  assign box    = (color_mode == MODE_BOX);

  // lane 0 divides the rounded luminance in box mode
  assign mul_a = box ? 17'(smp[0]) + 17'(smp[1]) : 17'(smp[0]) - 17'(low_ch[0]);
  assign mul_b = box ? $signed({1'b0, ncap, 1'b0}) : $signed({2'b00, ncap});
  assign num_next[0] = NUM_W'(mul_a) * NUM_W'(mul_b) + (box ? NUM_W'(high_ch[0]) : '0);
  assign den_next[0] = box ? DEN_W'(high_ch[0]) <<< 1 : DEN_W'(high_ch[0]) - DEN_W'(low_ch[0]);

  for (genvar c = 1; c < 3; c++) begin : g_num
    assign num_next[c] = NUM_W'(17'(smp[c]) - 17'(low_ch[c])) * NUM_W'($signed({1'b0, ncap}));
    assign den_next[c] = DEN_W'(high_ch[c]) - DEN_W'(low_ch[c]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], pixel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        num[c] <= num_next[c];
        den[c] <= den_next[c];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pcmi_lane u_lane (
      .clk (clk),
      .en  (adv),
      .num (num[c]),
      .den (den[c]),
      .quo (quo[c])
    );
  end

  pcmi_ratio #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS),
    .LAT           (LANE_LAT + 1)
  ) u_ratio (
    .clk  (clk),
    .en   (adv),
    .s0   (smp[0]),
    .s1   (smp[1]),
    .ncap (ncap),
    .iq   (iq)
  );

  always_comb begin
    ctl.mode = color_mode;
    ctl.ncap = ncap;
    case (color_mode)
      MODE_GRAY: ctl.range_error = (high_ch[0] == low_ch[0]);
      MODE_BOX:  ctl.range_error = (high_ch[0] == 16'sd0);
      MODE_CUBE: ctl.range_error = (high_ch[0] == low_ch[0]) || (high_ch[1] == low_ch[1]) ||
                                   (high_ch[2] == low_ch[2]);
      default:   ctl.range_error = 1'b0;
    endcase
  end

  pcmi_merge u_merge (
    .clk (clk),
    .en  (adv),
    .ctl (ctl),
    .q0  (quo[0]),
    .q1  (quo[1]),
    .q2  (quo[2]),
    .iq  (iq),
    .res (index)
  );

endmodule

// ===== tb/sv/pcmi_checker.sv =====
// Checker for the pixel to colormap index unit: predicts each index and compares.
module pcmi_checker import pcmi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  input  logic        pixel_stall,
  input  pixel_t      pixel,
  input  logic        index_valid,
  input  logic        index_stall,
  input  result_t     index,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  localparam int NMAX = 256;
  localparam int FRAC = 11;

  logic [1:0] mode_r;
  logic [8:0] levels_r;
  logic signed [15:0] low_r [3];
  logic signed [15:0] high_r [3];
  result_t expected_idx [$];

  function automatic longint clamp_lvl(longint v, longint n);
    if (v > n - 1) v = n - 1;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic longint div_floor(longint a, longint b);
    longint q;
    if (b < 0) begin
      a = -a;
      b = -b;
    end
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint log2_fixed(longint x);
    int e;
    longint m;
    e = 0;
    while (e < 16 && (x >> (e + 1)) != 0) e++;
    if (e >= 5) m = (x >> (e - 5)) & 31;
    else m = (x << (5 - e)) & 31;
    return longint'(e) * (longint'(1) << FRAC) + (longint'(LOG_MANT_Q16[m]) >> (16 - FRAC));
  endfunction

  function automatic result_t map_pixel(pixel_t p);
    longint s [3];
    longint n, idx, lo, df, h, lum, il, q, iq, d;
    result_t r;
    int chans;
    s[0] = p.sample_ch0;
    s[1] = p.sample_ch1;
    s[2] = p.sample_ch2;
    n = levels_r;
    if (n > NMAX) n = NMAX;
    idx = 0;
    r.range_error = 1'b0;
    if (mode_r == MODE_GRAY || mode_r == MODE_CUBE) begin
      chans = (mode_r == MODE_GRAY) ? 1 : 3;
      for (int c = 0; c < chans; c++) begin
        lo = low_r[c];
        df = longint'(high_r[c]) - lo;
        if (df == 0) begin
          r.range_error = 1'b1;
          break;
        end
        idx = idx * n + clamp_lvl((s[c] - lo) * n / df, n);
      end
      if (r.range_error) idx = 0;
    end else if (mode_r == MODE_BOX) begin
      h = high_r[0];
      if (h == 0) r.range_error = 1'b1;
      else begin
        lum = s[0] + s[1];
        il = clamp_lvl(div_floor(2 * n * lum + h, 2 * h), n);
        q = 0;
        if (s[0] != 0 && s[1] != 0) begin
          d = log2_fixed(s[1] < 0 ? -s[1] : s[1]) - log2_fixed(s[0] < 0 ? -s[0] : s[0]);
          q = div_floor(d * LN2_Q16 + 32768, 65536);
        end
        iq = clamp_lvl(n * ((longint'(1) << FRAC) + q) / (longint'(1) << (FRAC + 1)), n);
        idx = n * iq + il;
      end
    end
    if (idx > 255) idx = 255;
    if (idx < 0) idx = 0;
    r.shade_index = idx[7:0];
    return r;
  endfunction

  assign pending = expected_idx.size();

  always @(posedge clk) begin
    result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      mode_r <= MODE_GRAY;
      levels_r <= 9'd256;
      for (int c = 0; c < 3; c++) begin
        low_r[c] <= '0;
        high_r[c] <= 16'sd32767;
      end
      expected_idx.delete();
      fail_count <= 0;
    end else begin
      if (pixel_valid && !pixel_stall) expected_idx.push_back(map_pixel(pixel));
      if (index_valid && !index_stall) begin
        if (expected_idx.size() == 0) begin
          $error("unexpected index transfer %0d", index.shade_index);
          errs++;
        end else begin
          want = expected_idx.pop_front();
          if (want.shade_index !== index.shade_index) begin
            $error("shade_index expected %0d actual %0d", want.shade_index, index.shade_index);
            errs++;
          end
          if (want.range_error !== index.range_error) begin
            $error("range_error expected %0d actual %0d", want.range_error, index.range_error);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (cfg_we) begin
        case (cfg_index)
          REG_COLOR_MODE: mode_r <= cfg_data[1:0];
          REG_SHADE_LEVELS: levels_r <= cfg_data[8:0];
          REG_LOW_CH0, REG_LOW_CH1, REG_LOW_CH2: low_r[cfg_index - REG_LOW_CH0] <= cfg_data;
          default: high_r[cfg_index - REG_HIGH_CH0] <= cfg_data;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/tb_pixel_to_colormap_index_unit.sv =====
// Testbench top: drives pixels and register writes, idles both sides, gives the verdict.
module tb_pixel_to_colormap_index_unit;
  import pcmi_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic pixel_valid = 0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic index_valid;
  logic index_stall = 0;
  result_t index;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_COLOR_MODE;
  logic [15:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;
  bit stim_done = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  pixel_to_colormap_index_unit dut (.*);
  pcmi_checker chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_pixel(pixel_t p);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    pixel = p;
    pixel_valid = 1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    @(negedge clk);
    pixel_valid = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_bounds(logic [15:0] lo0, logic [15:0] hi0,
                              logic [15:0] lo1, logic [15:0] hi1,
                              logic [15:0] lo2, logic [15:0] hi2);
    write_reg(REG_LOW_CH0, lo0);
    write_reg(REG_HIGH_CH0, hi0);
    write_reg(REG_LOW_CH1, lo1);
    write_reg(REG_HIGH_CH1, hi1);
    write_reg(REG_LOW_CH2, lo2);
    write_reg(REG_HIGH_CH2, hi2);
  endtask

  // receiver stall
  always @(negedge clk) begin
    int hold;
    if (!rst) begin
      if (hold > 0) begin
        hold--;
        index_stall <= 1;
      end else if ($urandom_range(0, 99) < 25) begin
        hold = gap_len();
        index_stall <= (hold > 0);
      end else index_stall <= 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    pixel_t p;
    logic [15:0] ext [6];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: reset setting, field extremes, zero divisor, box mode, off mode, then cube mode
    send_pixel('{16'sh8000, 16'sh8000, 16'sh8000});
    send_pixel('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_pixel('{16'sh0000, 16'sh0001, 16'shffff});
    send_pixel('{16'sh4000, 16'shc000, 16'sh1234});
    drain();
    write_reg(REG_HIGH_CH0, 16'h0000);
    send_pixel('{16'sh0100, 16'sh0000, 16'sh0000});
    drain();
    write_reg(REG_COLOR_MODE, 16'(MODE_BOX));
    drain();
    send_pixel('{16'sh0100, 16'sh0200, 16'sh0000});
    drain();
    write_reg(REG_HIGH_CH0, 16'h0400);
    drain();
    send_pixel('{16'sh0000, 16'sh0200, 16'sh0000});
    send_pixel('{16'sh0100, 16'sh0000, 16'sh0000});
    send_pixel('{16'sh8000, 16'sh0001, 16'sh0000});
    send_pixel('{16'sh0001, 16'sh7fff, 16'sh0000});
    send_pixel('{16'shfff0, 16'sh0010, 16'sh0000});
    drain();
    write_reg(REG_COLOR_MODE, 16'(MODE_OFF));
    send_pixel('{16'sh0100, 16'sh0200, 16'sh0300});
    drain();
    write_reg(REG_COLOR_MODE, 16'(MODE_CUBE));
    write_reg(REG_SHADE_LEVELS, 16'd0);
    write_bounds(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_pixel('{16'sh0100, 16'sh0200, 16'sh0300});
    drain();
    write_reg(REG_SHADE_LEVELS, 16'd511);
    send_pixel('{16'sh0100, 16'sh0200, 16'sh0300});
    drain();
    write_reg(REG_HIGH_CH2, 16'h7fff);
    send_pixel('{16'sh0100, 16'sh0200, 16'sh0300});
    send_pixel('{16'sh8000, 16'sh7fff, 16'sh7fff});
    drain();
    // random phases over many settings
    for (int ph = 0; ph < 35; ph++) begin
      drain();
      write_reg(REG_COLOR_MODE, 16'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3)));
      case ($urandom_range(0, 4))
        0: write_reg(REG_SHADE_LEVELS, 16'($urandom_range(0, 1)));
        1: write_reg(REG_SHADE_LEVELS, 16'($urandom_range(256, 511)));
        default: write_reg(REG_SHADE_LEVELS, 16'($urandom_range(2, 16)));
      endcase
      for (int k = 0; k < 6; k++) begin
        ext[k] = pick_sample();
        if ($urandom_range(0, 3) == 0) ext[k] = (k & 1) ? 16'h7fff : 16'h8000;
      end
      if ($urandom_range(0, 7) == 0) ext[1] = ext[0];
      write_bounds(ext[0], ext[1], ext[2], ext[3], ext[4], ext[5]);
      for (int i = 0; i < 30; i++) begin
        p.sample_ch0 = pick_sample();
        p.sample_ch1 = pick_sample();
        p.sample_ch2 = pick_sample();
        send_pixel(p);
      end
    end
    drain();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
